// File: rtl/htwd_pkg.sv
package htwd_pkg;

  localparam int IDX_W    = 9;
  localparam int LETTER_W = 8;
  localparam int DATA_W   = 40;
  localparam int OUT_W    = LETTER_W + 1;

  // slave tdata layout
  localparam int NODE_LO   = 0;
  localparam int LEFT_LO   = 9;
  localparam int RIGHT_LO  = 18;
  localparam int LEAF_POS  = 27;
  localparam int LETTER_LO = 28;
  localparam int BIT_POS   = 36;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_BIT  = 1'b1;

  localparam logic REG_ROOT   = 1'b0;
  localparam logic REG_EXPECT = 1'b1;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic             re_a;
    logic [IDX_W-1:0] addr_a;
    logic             re_b;
    logic [IDX_W-1:0] addr_b;
  } mem_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] root_index;
    logic [31:0]      letters_expected;
    logic             wr_root;
    logic             wr_expect;
  } cfg_t;

endpackage

// File: rtl/htwd_node_mem.sv
module htwd_node_mem import htwd_pkg::*; #(
  parameter int NODE_COUNT = 512,
  parameter int EW         = 27
) (
  input  logic          clk,
  input  logic          rst,
  input  mem_req_t      req,
  input  logic [EW-1:0] wdata,
  output logic [EW-1:0] rd_a,
  output logic [EW-1:0] rd_b
);

  localparam int AW = $clog2(NODE_COUNT);

  logic [EW-1:0]    mem [NODE_COUNT];
  logic [EW-1:0]    q_a;
  logic [EW-1:0]    q_b;
  logic             ok_a;
  logic             ok_b;
  logic [IDX_W-1:0] held_a;
  logic [IDX_W-1:0] held_b;
  logic [EW-1:0]    fwd_a;
  logic [EW-1:0]    fwd_b;
  logic             fwd_a_vld;
  logic             fwd_b_vld;
  logic             w_ok;
  logic             ra_ok;
  logic             rb_ok;

  assign w_ok  = 32'(req.waddr) < NODE_COUNT;
  assign ra_ok = 32'(req.addr_a) < NODE_COUNT;
  assign rb_ok = 32'(req.addr_b) < NODE_COUNT;

  always_ff @(posedge clk) begin
    if (req.we && w_ok) begin
      mem[AW'(req.waddr)] <= wdata;
    end
    if (req.re_a) begin
      q_a <= mem[AW'(req.addr_a)];
    end
    if (req.re_b) begin
      q_b <= mem[AW'(req.addr_b)];
    end
  end

  // later writes to an entry already held on a read port
  always_ff @(posedge clk) begin
    if (req.re_a) begin
      ok_a   <= ra_ok;
      held_a <= req.addr_a;
    end
    if (req.re_b) begin
      ok_b   <= rb_ok;
      held_b <= req.addr_b;
    end
    if (!req.re_a && req.we && w_ok && ok_a && req.waddr == held_a) begin
      fwd_a <= wdata;
    end
    if (!req.re_b && req.we && w_ok && ok_b && req.waddr == held_b) begin
      fwd_b <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_a_vld <= 1'b0;
      fwd_b_vld <= 1'b0;
    end else begin
      if (req.re_a) begin
        fwd_a_vld <= 1'b0;
      end else if (req.we && w_ok && ok_a && req.waddr == held_a) begin
        fwd_a_vld <= 1'b1;
      end
      if (req.re_b) begin
        fwd_b_vld <= 1'b0;
      end else if (req.we && w_ok && ok_b && req.waddr == held_b) begin
        fwd_b_vld <= 1'b1;
      end
    end
  end

  assign rd_a = fwd_a_vld ? fwd_a : (ok_a ? q_a : '0);
  assign rd_b = fwd_b_vld ? fwd_b : (ok_b ? q_b : '0);

endmodule

// File: rtl/htwd_out_buf.sv
module htwd_out_buf import htwd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [OUT_W-1:0] push_data,
  output logic             ready,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] out_data
);

  logic             skid_valid;
  logic [OUT_W-1:0] skid_data;

  assign ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

// File: rtl/htwd_walk.sv
module htwd_walk import htwd_pkg::*; #(
  parameter int NODE_COUNT  = 512,
  parameter int LETTER_BITS = 8,
  parameter int EW          = 2 * IDX_W + 1 + LETTER_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_kind,
  input  logic [DATA_W-1:0] in_data,
  input  logic              buf_ready,
  output logic              push,
  output logic [OUT_W-1:0]  push_data,
  output mem_req_t          mreq,
  output logic [EW-1:0]     mwdata,
  input  logic [EW-1:0]     rd_a,
  input  logic [EW-1:0]     rd_b
);

  localparam int L_LO  = 0;
  localparam int R_LO  = IDX_W;
  localparam int LF    = 2 * IDX_W;
  localparam int LT_LO = 2 * IDX_W + 1;

  localparam logic [1:0] RF_IDLE  = 2'd0;
  localparam logic [1:0] RF_NODE  = 2'd1;
  localparam logic [1:0] RF_ROOTC = 2'd2;
  localparam logic [1:0] RF_CURC  = 2'd3;

  logic [1:0]       rf_state;
  logic             at_root;
  logic [IDX_W-1:0] cur_idx;
  logic [31:0]      done;
  logic [EW-1:0]    root_ent;
  logic [EW-1:0]    root_l;
  logic [EW-1:0]    root_r;
  logic [EW-1:0]    cur_ent;

  logic             acc;
  logic [IDX_W-1:0] node_index;
  logic             code_bit;
  logic             load_we;
  logic             load_hit;
  logic             padding;
  logic             bit_acc;
  logic [EW-1:0]    eff_ent;
  logic [EW-1:0]    ch_ent;
  logic [IDX_W-1:0] ch_idx;
  logic             emit;
  logic             descend;
  logic [31:0]      done_inc;
  logic [LETTER_BITS-1:0] emit_letter;

  assign in_ready   = (rf_state == RF_IDLE) && buf_ready;
  assign acc        = in_valid && in_ready;
  assign node_index = in_data[NODE_LO +: IDX_W];
  assign code_bit   = in_data[BIT_POS];

  assign mwdata = {LETTER_BITS'(in_data[LETTER_LO +: LETTER_W]), in_data[LEAF_POS],
                   in_data[RIGHT_LO +: IDX_W], in_data[LEFT_LO +: IDX_W]};

  assign load_we  = acc && in_kind == KIND_LOAD && 32'(node_index) < NODE_COUNT;
  assign load_hit = load_we &&
                    (node_index == cfg.root_index || (!at_root && node_index == cur_idx));

  assign padding  = cfg.letters_expected != 32'd0 && done >= cfg.letters_expected;
  assign bit_acc  = acc && in_kind == KIND_BIT && !padding;

  assign eff_ent = at_root ? root_ent : cur_ent;
  assign ch_ent  = code_bit ? (at_root ? root_r : rd_b) : (at_root ? root_l : rd_a);
  assign ch_idx  = code_bit ? eff_ent[R_LO +: IDX_W] : eff_ent[L_LO +: IDX_W];

  assign emit        = bit_acc && (eff_ent[LF] || ch_ent[LF]);
  assign descend     = bit_acc && !eff_ent[LF] && !ch_ent[LF];
  assign emit_letter = eff_ent[LF] ? eff_ent[LT_LO +: LETTER_BITS]
                                   : ch_ent[LT_LO +: LETTER_BITS];
  assign done_inc    = done + 32'd1;

  assign push      = emit;
  assign push_data = {cfg.letters_expected != 32'd0 && done_inc == cfg.letters_expected,
                      LETTER_W'(emit_letter)};

  always_comb begin
    mreq       = '0;
    mreq.we    = load_we;
    mreq.waddr = node_index;
    unique case (rf_state)
      RF_IDLE: begin
        mreq.re_a   = descend;
        mreq.addr_a = ch_ent[L_LO +: IDX_W];
        mreq.re_b   = descend;
        mreq.addr_b = ch_ent[R_LO +: IDX_W];
      end
      RF_NODE: begin
        mreq.re_a   = 1'b1;
        mreq.addr_a = cfg.root_index;
        mreq.re_b   = 1'b1;
        mreq.addr_b = cur_idx;
      end
      RF_ROOTC: begin
        mreq.re_a   = 1'b1;
        mreq.addr_a = rd_a[L_LO +: IDX_W];
        mreq.re_b   = 1'b1;
        mreq.addr_b = rd_a[R_LO +: IDX_W];
      end
      RF_CURC: begin
        mreq.re_a   = 1'b1;
        mreq.addr_a = cur_ent[L_LO +: IDX_W];
        mreq.re_b   = 1'b1;
        mreq.addr_b = cur_ent[R_LO +: IDX_W];
      end
      default: begin
        mreq.re_a = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_state <= RF_NODE;
      at_root  <= 1'b1;
      cur_idx  <= '0;
      done     <= '0;
    end else begin
      if (cfg.wr_root) begin
        rf_state <= RF_NODE;
      end else begin
        unique case (rf_state)
          RF_IDLE:  rf_state <= load_hit ? RF_NODE : RF_IDLE;
          RF_NODE:  rf_state <= RF_ROOTC;
          RF_ROOTC: rf_state <= RF_CURC;
          RF_CURC:  rf_state <= RF_IDLE;
          default:  rf_state <= RF_NODE;
        endcase
      end
      if (cfg.wr_root || emit) begin
        at_root <= 1'b1;
      end else if (descend) begin
        at_root <= 1'b0;
      end
      if (descend) begin
        cur_idx <= ch_idx;
      end
      if (cfg.wr_expect) begin
        done <= '0;
      end else if (emit) begin
        done <= done_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rf_state == RF_ROOTC) begin
      root_ent <= rd_a;
      cur_ent  <= rd_b;
    end else if (descend) begin
      cur_ent <= ch_ent;
    end
    if (rf_state == RF_CURC) begin
      root_l <= rd_a;
      root_r <= rd_b;
    end else if (load_we) begin
      if (node_index == root_ent[L_LO +: IDX_W]) begin
        root_l <= mwdata;
      end
      if (node_index == root_ent[R_LO +: IDX_W]) begin
        root_r <= mwdata;
      end
    end
  end

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(mreq.we && (mreq.re_a || mreq.re_b)))
    else $error("node table read and written in the same cycle");

  a_descend_leaves_root: assert property (@(posedge clk) disable iff (rst)
    descend && !cfg.wr_root |=> !at_root && !eff_ent[LF])
    else $error("walk moved onto a leaf");

  a_emit_returns: assert property (@(posedge clk) disable iff (rst)
    emit |=> at_root)
    else $error("walk did not return to root after a letter");

  a_no_emit_past_count: assert property (@(posedge clk) disable iff (rst)
    emit |-> cfg.letters_expected == 32'd0 || done < cfg.letters_expected)
    else $error("letter emitted after the expected count");

  a_refetch_done: assert property (@(posedge clk) disable iff (rst)
    rf_state == RF_CURC && !cfg.wr_root |=> rf_state == RF_IDLE)
    else $error("refetch sequence did not finish");

endmodule

// File: rtl/huffman_tree_walk_decoder_top.sv
// Huffman tree-walk decoder. Words with tuser = 0 load one node of the code tree into
// the node table; words with tuser = 1 carry one code bit and walk the tree from the
// current node, giving a letter on m_tdata each time a leaf is reached. One word is
// taken every cycle while the output side keeps up; a two-word output buffer lets the
// input run on while a letter waits. The walk keeps the current node and the entries of
// both its children ready, refilling them through the two read ports of the node table
// in the cycle after each step. Writing root_index, and loading the node at the root or
// at the current node, holds s_tready low while the root entry, the current entry and
// their children are fetched again, as also after reset. With letters_expected
// nonzero the letter that reaches the count carries m_tlast and later code bits are
// dropped until letters_expected is written again.
module huffman_tree_walk_decoder_top import htwd_pkg::*; #(
  parameter int NODE_COUNT  = 512,
  parameter int LETTER_BITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // node_index, left_child, right_child, is_leaf, leaf_letter, code_bit, zero pad
  input  logic [DATA_W-1:0] s_tdata,
  // kind
  input  logic [0:0]        s_tuser,
  output logic              m_tvalid,
  input  logic              m_tready,
  // letter
  output logic [7:0]        m_tdata,
  output logic              m_tlast,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int EW = 2 * IDX_W + 1 + LETTER_BITS;

  logic [IDX_W-1:0] root_index;
  logic [31:0]      letters_expected;
  logic             wr;
  cfg_t             cfg;
  mem_req_t         mreq;
  logic [EW-1:0]    mwdata;
  logic [EW-1:0]    rd_a;
  logic [EW-1:0]    rd_b;
  logic             buf_ready;
  logic             push;
  logic [OUT_W-1:0] push_data;
  logic [OUT_W-1:0] out_data;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_index       <= '0;
      letters_expected <= '0;
    end else if (wr) begin
      if (paddr[2] == REG_ROOT) begin
        root_index <= pwdata[IDX_W-1:0];
      end else begin
        letters_expected <= pwdata;
      end
    end
  end

  assign prdata = (paddr[2] == REG_EXPECT) ? letters_expected : 32'(root_index);

  assign cfg.root_index       = root_index;
  assign cfg.letters_expected = letters_expected;
  assign cfg.wr_root          = wr && paddr[2] == REG_ROOT;
  assign cfg.wr_expect        = wr && paddr[2] == REG_EXPECT;

  htwd_node_mem #(
    .NODE_COUNT(NODE_COUNT),
    .EW        (EW)
  ) u_mem (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .wdata(mwdata),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  htwd_walk #(
    .NODE_COUNT (NODE_COUNT),
    .LETTER_BITS(LETTER_BITS),
    .EW         (EW)
  ) u_walk (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_kind  (s_tuser[0]),
    .in_data  (s_tdata),
    .buf_ready(buf_ready),
    .push     (push),
    .push_data(push_data),
    .mreq     (mreq),
    .mwdata   (mwdata),
    .rd_a     (rd_a),
    .rd_b     (rd_b)
  );

  htwd_out_buf u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .ready    (buf_ready),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_data (out_data)
  );

  assign m_tdata = out_data[LETTER_W-1:0];
  assign m_tlast = out_data[LETTER_W];

endmodule

// File: dv/huffman_tree_walk_decoder_top_tb.sv
`timescale 1ns / 1ps

module huffman_tree_walk_decoder_top_tb;
  import htwd_pkg::*;

  localparam int NODES       = 512;
  localparam int WORD_TARGET = 1750;
  localparam int SETTLE      = 8;
  localparam int CYCLE_LIMIT = 500000;

  typedef enum logic [1:0] {ROW_LOAD, ROW_BIT, ROW_ROOT, ROW_EXPECT} row_e;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_LETTER} chk_e;

  typedef struct packed {
    logic [LETTER_W-1:0] letter;
    logic                last;
  } letter_t;

  typedef struct packed {
    chk_e    chk;
    letter_t typed;
  } word_tag_t;

  typedef struct packed {
    row_e                op;
    logic [IDX_W-1:0]    node;
    logic [IDX_W-1:0]    left;
    logic [IDX_W-1:0]    right;
    logic                leaf;
    logic [LETTER_W-1:0] ltr;
    logic                code;
    logic [31:0]         value;
    chk_e                chk;
    logic [LETTER_W-1:0] exp_letter;
    logic                exp_last;
  } row_t;

  localparam int DIR_ROWS = 31;

  row_t dir_tab [DIR_ROWS] = '{
    // single-leaf tree at the root
    '{ROW_LOAD,   9'd0,   9'd511, 9'd0,   1'b1, 8'hff, 1'b0, 32'd0, CHK_NONE,   8'h00, 1'b0},
    '{ROW_BIT,    0, 0, 0, 0, 0,                      1'b0, 32'd0, CHK_LETTER, 8'hff, 1'b0},
    '{ROW_BIT,    0, 0, 0, 0, 0,                      1'b1, 32'd0, CHK_LETTER, 8'hff, 1'b0},
    '{ROW_EXPECT, 0, 0, 0, 0, 0,                      1'b0, 32'd2, CHK_NONE,   8'h00, 1'b0},
    '{ROW_BIT,    0, 0, 0, 0, 0,                      1'b1, 32'd0, CHK_LETTER, 8'hff, 1'b0},
    '{ROW_BIT,    0, 0, 0, 0, 0,                      1'b0, 32'd0, CHK_LETTER, 8'hff, 1'b1},
    // padding once the count is reached
    '{ROW_BIT,    0, 0, 0, 0, 0,                      1'b1, 32'd0, CHK_NONE,   8'h00, 1'b0},
    '{ROW_EXPECT, 0, 0, 0, 0, 0,                      1'b0, 32'd0, CHK_NONE,   8'h00, 1'b0},
    // small tree rooted at the top entry, node 4 loops on itself
    '{ROW_LOAD,   9'd1,   9'd0,   9'd511, 1'b1, 8'h00, 1'b0, 32'd0, CHK_NONE,   8'h00, 1'b0},
    '{ROW_LOAD,   9'd3,   9'd511, 9'd511, 1'b1, 8'h5a, 1'b1, 32'd0, CHK_NONE,   8'h00, 1'b0},
    '{ROW_LOAD,   9'd4,   9'd4,   9'd3,   1'b0, 8'h33, 1'b0, 32'd0, CHK_NONE,   8'h00, 1'b0},
    '{ROW_LOAD,   9'd2,   9'd3,   9'd4,   1'b0, 8'h0f, 1'b0, 32'd0, CHK_NONE,   8'h00, 1'b0},
    '{ROW_LOAD,   9'd511, 9'd1,   9'd2,   1'b0, 8'hc3, 1'b1, 32'd0, CHK_NONE,   8'h00, 1'b0},
    '{ROW_ROOT,   0, 0, 0, 0, 0,                      1'b0, 32'd511, CHK_NONE,  8'h00, 1'b0},
    '{ROW_BIT,    0, 0, 0, 0, 0,                      1'b0, 32'd0, CHK_MODEL,  8'h00, 1'b0},
    '{ROW_BIT,    0, 0, 0, 0, 0,                      1'b1, 32'd0, CHK_MODEL,  8'h00, 1'b0},
    '{ROW_BIT,    0, 0, 0, 0, 0,                      1'b0, 32'd0, CHK_MODEL,  8'h00, 1'b0},
    '{ROW_BIT,    0, 0, 0, 0, 0,                      1'b1, 32'd0, CHK_MODEL,  8'h00, 1'b0},
    '{ROW_BIT,    0, 0, 0, 0, 0,                      1'b1, 32'd0, CHK_MODEL,  8'h00, 1'b0},
    '{ROW_BIT,    0, 0, 0, 0, 0,                      1'b0, 32'd0, CHK_MODEL,  8'h00, 1'b0},
    '{ROW_BIT,    0, 0, 0, 0, 0,                      1'b0, 32'd0, CHK_MODEL,  8'h00, 1'b0},
    // current node turned into a leaf under the walk
    '{ROW_LOAD,   9'd4,   9'd0,   9'd0,   1'b1, 8'ha5, 1'b0, 32'd0, CHK_NONE,   8'h00, 1'b0},
    '{ROW_BIT,    0, 0, 0, 0, 0,                      1'b1, 32'd0, CHK_MODEL,  8'h00, 1'b0},
    '{ROW_EXPECT, 0, 0, 0, 0, 0,                      1'b0, 32'hffffffff, CHK_NONE, 8'h00, 1'b0},
    '{ROW_BIT,    0, 0, 0, 0, 0,                      1'b1, 32'd0, CHK_MODEL,  8'h00, 1'b0},
    '{ROW_BIT,    0, 0, 0, 0, 0,                      1'b1, 32'd0, CHK_MODEL,  8'h00, 1'b0},
    // partly walked code dropped by a root write
    '{ROW_BIT,    0, 0, 0, 0, 0,                      1'b1, 32'd0, CHK_MODEL,  8'h00, 1'b0},
    '{ROW_ROOT,   0, 0, 0, 0, 0,                      1'b0, 32'd0, CHK_NONE,   8'h00, 1'b0},
    '{ROW_BIT,    0, 0, 0, 0, 0,                      1'b0, 32'd0, CHK_LETTER, 8'hff, 1'b0},
    '{ROW_EXPECT, 0, 0, 0, 0, 0,                      1'b0, 32'd1, CHK_NONE,   8'h00, 1'b0},
    '{ROW_BIT,    0, 0, 0, 0, 0,                      1'b1, 32'd0, CHK_LETTER, 8'hff, 1'b1}
  };

  logic              clk;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata  = '0;
  logic [0:0]        s_tuser  = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [7:0]        m_tdata;
  logic              m_tlast;
  logic              psel     = 1'b0;
  logic              penable  = 1'b0;
  logic              pwrite   = 1'b0;
  logic [2:0]        paddr    = '0;
  logic [31:0]       pwdata   = '0;
  logic [31:0]       prdata;
  logic              pready;

  huffman_tree_walk_decoder_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // predicted decoder state
  bit [IDX_W-1:0]    nd_left   [NODES];
  bit [IDX_W-1:0]    nd_right  [NODES];
  bit                nd_leaf   [NODES];
  bit [LETTER_W-1:0] nd_letter [NODES];
  bit [IDX_W-1:0]    cur_node;
  bit [31:0]         done_cnt;
  bit [IDX_W-1:0]    root_reg;
  bit [31:0]         limit_reg;

  word_tag_t        tag_q[$];
  letter_t          letter_q[$];
  bit               node_seen [NODES];
  logic [IDX_W-1:0] seen_list[$];
  bit               in_tree [NODES];

  int mismatches;
  int words_sent;
  int letters_seen;
  int lasts_seen;
  int reg_writes;
  int burst_left;
  int cycle_cnt;
  int rdy_pct = 100;
  int rdy_run;

  function automatic logic [DATA_W-1:0] pack_word(input logic [IDX_W-1:0] node,
                                                  input logic [IDX_W-1:0] left,
                                                  input logic [IDX_W-1:0] right,
                                                  input logic leaf,
                                                  input logic [LETTER_W-1:0] ltr,
                                                  input logic code);
    logic [DATA_W-1:0] w;
    w = '0;
    w[NODE_LO +: IDX_W]     = node;
    w[LEFT_LO +: IDX_W]     = left;
    w[RIGHT_LO +: IDX_W]    = right;
    w[LEAF_POS]             = leaf;
    w[LETTER_LO +: LETTER_W] = ltr;
    w[BIT_POS]              = code;
    return w;
  endfunction

  function automatic void walk_tree(input logic kind, input logic [DATA_W-1:0] d,
                                    output logic hit, output letter_t res);
    logic [IDX_W-1:0]    idx;
    logic [IDX_W-1:0]    child;
    logic [LETTER_W-1:0] ltr;
    hit = 1'b0;
    res = '0;
    ltr = '0;
    if (kind == KIND_LOAD) begin
      idx            = d[NODE_LO +: IDX_W];
      nd_left[idx]   = d[LEFT_LO +: IDX_W];
      nd_right[idx]  = d[RIGHT_LO +: IDX_W];
      nd_leaf[idx]   = d[LEAF_POS];
      nd_letter[idx] = d[LETTER_LO +: LETTER_W];
    end else if (limit_reg == 0 || done_cnt < limit_reg) begin
      if (nd_leaf[cur_node]) begin
        hit = 1'b1;
        ltr = nd_letter[cur_node];
      end else begin
        child = d[BIT_POS] ? nd_right[cur_node] : nd_left[cur_node];
        if (nd_leaf[child]) begin
          hit = 1'b1;
          ltr = nd_letter[child];
        end else begin
          cur_node = child;
        end
      end
      if (hit) begin
        res.letter = ltr;
        res.last   = (limit_reg != 0) && (done_cnt + 32'd1 == limit_reg);
        done_cnt   = done_cnt + 32'd1;
        cur_node   = root_reg;
      end
    end
  endfunction

  function automatic logic [IDX_W-1:0] pick_fresh();
    logic [IDX_W-1:0] idx;
    do
      idx = $urandom;
    while (in_tree[idx]);
    in_tree[idx] = 1'b1;
    return idx;
  endfunction

  always @(posedge clk) begin : predict
    word_tag_t   tg;
    letter_t     res;
    letter_t     want;
    logic        hit;
    logic [31:0] rd_want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        tg = tag_q.pop_front();
        walk_tree(s_tuser[0], s_tdata, hit, res);
        if (tg.chk == CHK_MODEL && hit) begin
          letter_q.push_back(res);
        end else if (tg.chk == CHK_LETTER) begin
          letter_q.push_back(tg.typed);
        end
      end
      if (m_tvalid && m_tready) begin
        letters_seen++;
        if (m_tlast) begin
          lasts_seen++;
        end
        if (letter_q.size() == 0) begin
          $display("%0t: letter word %02h last %0b with none expected", $time, m_tdata, m_tlast);
          mismatches++;
        end else begin
          want = letter_q.pop_front();
          if (m_tdata !== want.letter) begin
            $display("%0t: letter expected %02h actual %02h", $time, want.letter, m_tdata);
            mismatches++;
          end
          if (m_tlast !== want.last) begin
            $display("%0t: last flag expected %0b actual %0b", $time, want.last, m_tlast);
            mismatches++;
          end
        end
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_ROOT) begin
            root_reg = pwdata[IDX_W-1:0];
            cur_node = pwdata[IDX_W-1:0];
          end else begin
            limit_reg = pwdata;
            done_cnt  = '0;
          end
        end else begin
          rd_want = (paddr[2] == REG_ROOT) ? 32'(root_reg) : limit_reg;
          if (prdata !== rd_want) begin
            $display("%0t: register %0d read expected %08h actual %08h", $time, paddr,
                     rd_want, prdata);
            mismatches++;
          end
        end
      end
    end
  end

  // receiver stalls, with a ready percentage picked anew after each random run
  always @(posedge clk) begin
    if (rdy_run == 0) begin
      case ($urandom_range(0, 3))
        0:       rdy_pct = 100;
        1:       rdy_pct = 80;
        2:       rdy_pct = 50;
        default: rdy_pct = 15;
      endcase
      rdy_run = $urandom_range(50, 300);
    end else begin
      rdy_run--;
    end
    m_tready <= ($urandom_range(0, 99) < rdy_pct);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_word(input logic kind, input logic [DATA_W-1:0] data, input chk_e chk,
                           input letter_t typed);
    word_tag_t        tg;
    logic [IDX_W-1:0] idx;
    int               gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 12);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    tg.chk   = chk;
    tg.typed = typed;
    tag_q.push_back(tg);
    idx = data[NODE_LO +: IDX_W];
    if (kind == KIND_LOAD && !node_seen[idx]) begin
      node_seen[idx] = 1'b1;
      seen_list.push_back(idx);
    end
    s_tdata  <= data;
    s_tuser  <= kind;
    s_tvalid <= 1'b1;
    do
      @(posedge clk);
    while (!s_tready);
    words_sent++;
  endtask

  task automatic settle_stream();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (letter_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [31:0] val);
    settle_stream();
    paddr   <= {sel, 2'b00};
    pwdata  <= val;
    pwrite  <= 1'b1;
    psel    <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    do
      @(posedge clk);
    while (!pready);
    // read back straight after
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do
      @(posedge clk);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    reg_writes++;
  endtask

  initial begin
    letter_t          typed;
    logic [IDX_W-1:0] forest[$];
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] ka;
    logic [IDX_W-1:0] kb;
    logic [31:0]      lim;
    int               pos;
    int               n_leaves;
    int               n_bits;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      typed.letter = dir_tab[i].exp_letter;
      typed.last   = dir_tab[i].exp_last;
      case (dir_tab[i].op)
        ROW_ROOT:   write_reg(REG_ROOT, dir_tab[i].value);
        ROW_EXPECT: write_reg(REG_EXPECT, dir_tab[i].value);
        default: begin
          send_word((dir_tab[i].op == ROW_LOAD) ? KIND_LOAD : KIND_BIT,
                    pack_word(dir_tab[i].node, dir_tab[i].left, dir_tab[i].right,
                              dir_tab[i].leaf, dir_tab[i].ltr, dir_tab[i].code),
                    dir_tab[i].chk, typed);
        end
      endcase
    end

    // random trees built bottom-up, so every internal node points at loaded entries
    while (words_sent < WORD_TARGET) begin
      foreach (in_tree[i]) in_tree[i] = 1'b0;
      forest.delete();
      n_leaves = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      repeat (n_leaves) begin
        idx = pick_fresh();
        send_word(KIND_LOAD, pack_word(idx, $urandom, $urandom, 1'b1, $urandom, $urandom),
                  CHK_MODEL, '0);
        forest.push_back(idx);
      end
      while (forest.size() > 1) begin
        pos = $urandom_range(0, forest.size() - 1);
        ka  = forest[pos];
        forest.delete(pos);
        pos = $urandom_range(0, forest.size() - 1);
        kb  = forest[pos];
        forest.delete(pos);
        idx = pick_fresh();
        send_word(KIND_LOAD, pack_word(idx, ka, kb, 1'b0, $urandom, $urandom), CHK_MODEL, '0);
        forest.push_back(idx);
      end
      if ($urandom_range(0, 6) != 0) begin
        write_reg(REG_ROOT, 32'(forest[0]));
      end
      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: lim = 32'd0;
          4, 5, 6, 7: lim = $urandom_range(1, 30);
          8:          lim = 32'hffffffff;
          default:    lim = $urandom;
        endcase
        write_reg(REG_EXPECT, lim);
      end
      n_bits = $urandom_range(10, 90);
      repeat (n_bits) begin
        if ($urandom_range(0, 11) == 0) begin
          // stray node reload in the middle of the code, may close a loop
          idx = $urandom;
          if ($urandom_range(0, 1) == 0) begin
            send_word(KIND_LOAD, pack_word(idx, $urandom, $urandom, 1'b1, $urandom, $urandom),
                      CHK_MODEL, '0);
          end else begin
            ka = seen_list[$urandom_range(0, seen_list.size() - 1)];
            kb = seen_list[$urandom_range(0, seen_list.size() - 1)];
            send_word(KIND_LOAD, pack_word(idx, ka, kb, 1'b0, $urandom, $urandom),
                      CHK_MODEL, '0);
          end
        end else begin
          send_word(KIND_BIT, pack_word($urandom, $urandom, $urandom, $urandom, $urandom,
                                        $urandom), CHK_MODEL, '0);
        end
      end
    end

    settle_stream();
    $display("run: %0d input words and %0d register writes, including single-leaf,",
             words_sent, reg_writes);
    $display("run: looped and random code trees; %0d letters out, %0d flagged last",
             letters_seen, lasts_seen);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
